@@ hw/rtl/rmc_pkg.sv @@
// ----------------------------------------------------------------------------
// rmc_pkg: shared types and constants for the region merge cost block
// Register indexes, item modes, sequencer codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_WEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPACT_WEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_THRESHOLD = 3'd3;

  localparam logic [1:0] MODE_GEO_A  = 2'd0;
  localparam logic [1:0] MODE_GEO_B  = 2'd1;
  localparam logic [1:0] MODE_BAND_A = 2'd2;
  localparam logic [1:0] MODE_BAND_B = 2'd3;

  localparam int PERIM_W  = 23;
  localparam int SHARED_W = 22;
  localparam int MEAN_W   = 24;
  localparam int SQ_W     = 36;
  localparam int SUM_W    = 28;
  localparam int STD_W    = 24;
  localparam int COST_W   = 48;
  localparam int WEIGHT_W = 17;
  localparam int BCNT_W   = 4;

  localparam int DVD_W = 80;
  localparam int DVS_W = 32;

  localparam logic [WEIGHT_W-1:0] Q16_ONE = 17'd65536;
  localparam logic [63:0]         MASK48  = 64'h0000_FFFF_FFFF_FFFF;

  localparam logic [BCNT_W-1:0]   RST_BAND_COUNT = 4'd1;
  localparam logic [WEIGHT_W-1:0] RST_COLOR_W    = 17'd58982;
  localparam logic [WEIGHT_W-1:0] RST_COMPACT_W  = 17'd32768;
  localparam logic [COST_W-1:0]   RST_SCALE_THR  = 48'd3276800;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    STP_MUL_MA,
    STP_MUL_MB,
    STP_DIV_MEAN,
    STP_MUL_MM,
    STP_MUL_T3,
    STP_MUL_T2,
    STP_DIV_VAR,
    STP_SQRT_VAR,
    STP_MUL_Y,
    STP_MUL_ZA,
    STP_MUL_ZB,
    STP_BAND_END,
    STP_MUL_COL,
    STP_MUL_SMOOTH,
    STP_DIV_SMOOTH,
    STP_SQRT_AREA,
    STP_MUL_COMPACT,
    STP_W_COMPACT,
    STP_W_SMOOTH,
    STP_W_SPATIAL
  } step_t;

  typedef enum logic [1:0] {
    UNIT_NONE,
    UNIT_MUL,
    UNIT_DIV,
    UNIT_SQRT
  } unit_t;

  function automatic unit_t unit_of(input step_t s);
    unit_t u;
    unique case (s)
      STP_DIV_MEAN, STP_DIV_VAR, STP_DIV_SMOOTH: u = UNIT_DIV;
      STP_SQRT_VAR, STP_SQRT_AREA:               u = UNIT_SQRT;
      STP_BAND_END:                              u = UNIT_NONE;
      default:                                   u = UNIT_MUL;
    endcase
    return u;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = (66'sd1 <<< 47) - 66'sd1;
    lo = -hi - 66'sd1;
    if (v > hi) return hi[47:0];
    if (v < lo) return lo[47:0];
    return v[47:0];
  endfunction

  // round half away from zero at Q.16, sign applied to the magnitude
  function automatic logic signed [63:0] round_q16(input logic [63:0] p, input logic neg);
    logic [64:0] s;
    logic [63:0] r;
    s = {1'b0, p} + 65'd32768;
    r = {15'b0, s[64:16]};
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [47:0] abs48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

endpackage

@@ hw/rtl/region_merge_cost.sv @@
// ----------------------------------------------------------------------------
// region_merge_cost: cost of fusing two image regions
// Colour heterogeneity over the bands plus an optional shape term, Q.16.
// ----------------------------------------------------------------------------
// Geometry and A-band requests are taken without leaving the idle state.
// A B-band request runs, unless both areas are zero, eight bit-serial multiplies
// (one multiplier bit a cycle), two 80-step restoring divides and a 32-step
// square root, all on one shared set of units; the last band adds the
// weighting and, below the threshold, the shape term, then registers the result.
// Input stalls until a request is done; sync active-low reset loads defaults.
module region_merge_cost #(
  parameter int MAX_BANDS  = 8,
  parameter int AREA_BITS  = 20,
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic [AREA_BITS:0]              in_area,
  input  logic [22:0]                     in_perimeter,
  input  logic [COORD_BITS-1:0]           in_box_x,
  input  logic [COORD_BITS-1:0]           in_box_y,
  input  logic [COORD_BITS:0]             in_box_w,
  input  logic [COORD_BITS:0]             in_box_h,
  input  logic [21:0]                     in_shared_edges,
  input  logic [23:0]                     in_band_mean,
  input  logic [35:0]                     in_band_square_sum,
  input  logic [27:0]                     in_band_color_sum,
  input  logic [23:0]                     in_band_std,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [47:0]              out_merge_cost,
  output logic                            out_shape_included,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rmc_pkg::*;

  localparam int AW     = AREA_BITS + 1;
  localparam int ASUM_W = AW + 1;
  localparam int CW     = COORD_BITS;
  localparam int SW     = CW + 1;
  localparam int EW     = CW + 2;
  localparam int LEN_W  = CW + 4;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [BCNT_W-1:0]   band_count_r;
  logic [WEIGHT_W-1:0] color_weight_r, compact_weight_r;
  logic [COST_W-1:0]   scale_thr_r;

  logic [AW-1:0]       area_a_r, area_b_r;
  logic [PERIM_W-1:0]  perim_a_r, perim_b_r;
  logic [CW-1:0]       box_ax_r, box_ay_r, box_bx_r, box_by_r;
  logic [SW-1:0]       box_aw_r, box_ah_r, box_bw_r, box_bh_r;
  logic [SHARED_W-1:0] shared_r;
  logic [MEAN_W-1:0]   pa_mean_r, pb_mean_r;
  logic [SQ_W-1:0]     pa_sq_r, pb_sq_r;
  logic [SUM_W-1:0]    pa_sum_r, pb_sum_r;
  logic [STD_W-1:0]    pa_std_r, pb_std_r;
  logic signed [47:0]  color_acc_r;
  logic [BCNT_W-1:0]   band_cnt_r;

  logic [63:0]         acc_r, tmp_r;
  logic [MEAN_W:0]     mean_r;
  logic signed [63:0]  cost_r, smooth_r, compact_r;
  logic                neg_r, shape_r;
  logic [1:0]          k_r;

  logic                out_valid_r, out_shape_r;
  logic [47:0]         out_cost_r;

  logic [63:0]         mul_a_r, mul_p_r;
  logic [31:0]         mul_b_r;
  logic [32:0]         div_rem_r;
  logic [DVD_W-1:0]    div_quo_r;
  logic [DVS_W-1:0]    div_d_r;
  logic [6:0]          div_cnt_r;
  logic [63:0]         sq_v_r;
  logic [35:0]         sq_rem_r;
  logic [31:0]         sq_root_r;
  logic [5:0]          sq_cnt_r;

  logic                in_acc, cfg_acc, out_free;
  logic                mul_go, div_go, sq_go, unit_done, commit, issue_go;
  logic [63:0]         mul_a_in;
  logic [31:0]         mul_b_in;
  logic [DVD_W-1:0]    div_n_in;
  logic [DVS_W-1:0]    div_d_in;
  logic [63:0]         sq_in;
  logic                neg_in;

  // ---------------------------------------------------------------- handshakes
  assign in_stall           = (state_r != ST_IDLE);
  assign in_acc             = in_valid && (state_r == ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign cfg_acc            = cfg_valid;
  assign out_valid          = out_valid_r;
  assign out_merge_cost     = $signed(out_cost_r);
  assign out_shape_included = out_shape_r;
  assign out_free           = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- derived values
  logic [ASUM_W-1:0]  area_sum;
  logic signed [25:0] perim_m, perim_k;
  logic [ASUM_W-1:0]  area_k;
  logic [LEN_W-1:0]   len_a, len_b, len_m, len_k;
  logic [24:0]        pmag_k;
  logic [CW-1:0]      x0, y0;
  logic [EW-1:0]      end_xa, end_xb, end_ya, end_yb, span_x, span_y;
  logic [WEIGHT_W-1:0] cw_c, colw_c;
  logic [4:0]         nb;
  logic               more_bands;
  logic [SUM_W:0]     sum_ab;
  logic [SQ_W:0]      sq_ab;
  logic [64:0]        t1_t3, var_sum;
  logic signed [47:0] comp48, smooth48, spat48;
  logic signed [63:0] rnd;
  logic               below_thr, cap;
  logic [63:0]        sterm, term;

  assign area_sum = {1'b0, area_a_r} + {1'b0, area_b_r};
  assign perim_m  = $signed({3'b0, perim_a_r}) + $signed({3'b0, perim_b_r})
                  - $signed({3'b0, shared_r, 1'b0});

  assign x0     = (box_ax_r < box_bx_r) ? box_ax_r : box_bx_r;
  assign y0     = (box_ay_r < box_by_r) ? box_ay_r : box_by_r;
  assign end_xa = EW'(box_ax_r) + EW'(box_aw_r);
  assign end_xb = EW'(box_bx_r) + EW'(box_bw_r);
  assign end_ya = EW'(box_ay_r) + EW'(box_ah_r);
  assign end_yb = EW'(box_by_r) + EW'(box_bh_r);
  assign span_x = ((end_xa > end_xb) ? end_xa : end_xb) - EW'(x0);
  assign span_y = ((end_ya > end_yb) ? end_ya : end_yb) - EW'(y0);
  assign len_m  = {({1'b0, span_x} + {1'b0, span_y}), 1'b0};
  assign len_a  = LEN_W'({({1'b0, box_aw_r} + {1'b0, box_ah_r}), 1'b0});
  assign len_b  = LEN_W'({({1'b0, box_bw_r} + {1'b0, box_bh_r}), 1'b0});

  // term order: merged region first, then B, then A
  always_comb begin
    case (k_r)
      2'd0: begin
        area_k  = area_sum;
        perim_k = perim_m;
        len_k   = len_m;
      end
      2'd1: begin
        area_k  = ASUM_W'(area_b_r);
        perim_k = $signed({3'b0, perim_b_r});
        len_k   = len_b;
      end
      default: begin
        area_k  = ASUM_W'(area_a_r);
        perim_k = $signed({3'b0, perim_a_r});
        len_k   = len_a;
      end
    endcase
  end

  always_comb begin
    logic [25:0] pm_abs;
    pm_abs = perim_k[25] ? 26'(-perim_k) : 26'(perim_k);
    pmag_k = pm_abs[24:0];
  end

  assign cw_c   = (compact_weight_r > Q16_ONE) ? Q16_ONE : compact_weight_r;
  assign colw_c = (color_weight_r > Q16_ONE) ? Q16_ONE : color_weight_r;

  assign nb = (band_count_r == '0) ? 5'd1 :
              (({1'b0, band_count_r} > 5'(MAX_BANDS)) ? 5'(MAX_BANDS) : {1'b0, band_count_r});
  assign more_bands = (({1'b0, band_cnt_r} + 5'd1) < nb);

  assign sum_ab  = {1'b0, pa_sum_r} + {1'b0, pb_sum_r};
  assign sq_ab   = {1'b0, pa_sq_r} + {1'b0, pb_sq_r};
  assign t1_t3   = 65'({sq_ab, 16'b0}) + {1'b0, acc_r};
  assign var_sum = (t1_t3 > {1'b0, tmp_r}) ? (t1_t3 - {1'b0, tmp_r}) : 65'd0;

  assign comp48   = sat48({{2{compact_r[63]}}, compact_r});
  assign smooth48 = sat48({{2{smooth_r[63]}}, smooth_r});
  assign spat48   = $signed(acc_r[47:0]);

  assign rnd       = round_q16(mul_p_r, neg_r);
  assign below_thr = (rnd < $signed({16'b0, scale_thr_r}));
  assign cap       = (tmp_r >= (64'(len_k) << 40));
  assign term      = cap ? (64'd1 << 56) : div_quo_r[63:0];
  assign sterm     = neg_r ? 64'(-$signed(term)) : term;

  // ---------------------------------------------------------------- unit operands
  always_comb begin
    mul_a_in = '0;
    mul_b_in = '0;
    div_n_in = '0;
    div_d_in = 32'(area_sum);
    sq_in    = {tmp_r[47:0], 16'b0};
    neg_in   = neg_r;
    case (step_r)
      STP_MUL_MA:      begin mul_a_in = 64'(pa_mean_r); mul_b_in = 32'(area_a_r); end
      STP_MUL_MB:      begin mul_a_in = 64'(pb_mean_r); mul_b_in = 32'(area_b_r); end
      STP_DIV_MEAN:    div_n_in = DVD_W'(acc_r);
      STP_MUL_MM:      begin mul_a_in = 64'(mean_r); mul_b_in = 32'(mean_r); end
      STP_MUL_T3:      begin mul_a_in = tmp_r; mul_b_in = 32'(area_sum); end
      STP_MUL_T2:      begin mul_a_in = 64'(sum_ab); mul_b_in = 32'({mean_r, 1'b0}); end
      STP_DIV_VAR:     div_n_in = DVD_W'(var_sum);
      STP_MUL_Y:       begin mul_a_in = tmp_r; mul_b_in = 32'(area_sum); end
      STP_MUL_ZA:      begin mul_a_in = 64'(pa_std_r); mul_b_in = 32'(area_a_r); end
      STP_MUL_ZB:      begin mul_a_in = 64'(pb_std_r); mul_b_in = 32'(area_b_r); end
      STP_MUL_COL: begin
        mul_a_in = 64'(abs48(color_acc_r));
        mul_b_in = 32'(colw_c);
        neg_in   = color_acc_r[47];
      end
      STP_MUL_SMOOTH: begin
        mul_a_in = 64'(pmag_k);
        mul_b_in = 32'(area_k);
        neg_in   = perim_k[25];
      end
      STP_DIV_SMOOTH: begin
        div_n_in = {tmp_r, 16'b0} + DVD_W'(len_k >> 1);
        div_d_in = 32'(len_k);
      end
      STP_SQRT_AREA:   sq_in = {32'(area_k), 32'b0};
      STP_MUL_COMPACT: begin mul_a_in = 64'(pmag_k); mul_b_in = tmp_r[31:0]; end
      STP_W_COMPACT: begin
        mul_a_in = 64'(abs48(comp48));
        mul_b_in = 32'(cw_c);
        neg_in   = comp48[47];
      end
      STP_W_SMOOTH: begin
        mul_a_in = 64'(abs48(smooth48));
        mul_b_in = 32'(Q16_ONE - cw_c);
        neg_in   = smooth48[47];
      end
      STP_W_SPATIAL: begin
        mul_a_in = 64'(abs48(spat48));
        mul_b_in = 32'(Q16_ONE - colw_c);
        neg_in   = spat48[47];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STP_MUL_MA;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    issue_go  = 1'b0;
    unit_done = 1'b1;
    unique case (unit_of(step_r))
      UNIT_MUL:  unit_done = (mul_b_r == '0);
      UNIT_DIV:  unit_done = (div_cnt_r == '0);
      UNIT_SQRT: unit_done = (sq_cnt_r == '0);
      default:   unit_done = 1'b1;
    endcase
    commit = (state_r == ST_WAIT) && unit_done;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_BAND_B) begin
          state_nxt = ST_ISSUE;
          step_nxt  = STP_MUL_MA;
        end
      end
      ST_ISSUE: begin
        case (step_r)
          STP_MUL_MA: begin
            if (area_sum == '0) begin
              step_nxt = STP_BAND_END;
            end else begin
              state_nxt = ST_WAIT;
              issue_go  = 1'b1;
            end
          end
          STP_DIV_SMOOTH: begin
            if (len_k == '0) begin
              step_nxt = STP_SQRT_AREA;
            end else begin
              state_nxt = ST_WAIT;
              issue_go  = 1'b1;
            end
          end
          STP_BAND_END: begin
            if (more_bands) state_nxt = ST_IDLE;
            else            step_nxt  = STP_MUL_COL;
          end
          default: begin
            state_nxt = ST_WAIT;
            issue_go  = 1'b1;
          end
        endcase
      end
      ST_WAIT: begin
        if (unit_done) begin
          state_nxt = ST_ISSUE;
          case (step_r)
            STP_MUL_MA:      step_nxt = STP_MUL_MB;
            STP_MUL_MB:      step_nxt = STP_DIV_MEAN;
            STP_DIV_MEAN:    step_nxt = STP_MUL_MM;
            STP_MUL_MM:      step_nxt = STP_MUL_T3;
            STP_MUL_T3:      step_nxt = STP_MUL_T2;
            STP_MUL_T2:      step_nxt = STP_DIV_VAR;
            STP_DIV_VAR:     step_nxt = STP_SQRT_VAR;
            STP_SQRT_VAR:    step_nxt = STP_MUL_Y;
            STP_MUL_Y:       step_nxt = STP_MUL_ZA;
            STP_MUL_ZA:      step_nxt = STP_MUL_ZB;
            STP_MUL_ZB:      step_nxt = STP_BAND_END;
            STP_MUL_COL: begin
              if (below_thr) step_nxt  = STP_MUL_SMOOTH;
              else           state_nxt = ST_OUT;
            end
            STP_MUL_SMOOTH:  step_nxt = STP_DIV_SMOOTH;
            STP_DIV_SMOOTH:  step_nxt = STP_SQRT_AREA;
            STP_SQRT_AREA:   step_nxt = STP_MUL_COMPACT;
            STP_MUL_COMPACT: step_nxt = (k_r == 2'd2) ? STP_W_COMPACT : STP_MUL_SMOOTH;
            STP_W_COMPACT:   step_nxt = STP_W_SMOOTH;
            STP_W_SMOOTH:    step_nxt = STP_W_SPATIAL;
            default:         state_nxt = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    mul_go = issue_go && (unit_of(step_r) == UNIT_MUL);
    div_go = issue_go && (unit_of(step_r) == UNIT_DIV);
    sq_go  = issue_go && (unit_of(step_r) == UNIT_SQRT);
  end

  // ---------------------------------------------------------------- shared units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_b_r <= '0;
    end else if (mul_go) begin
      mul_b_r <= mul_b_in;
    end else if (mul_b_r != '0) begin
      mul_b_r <= mul_b_r >> 1;
    end
  end

  // shift-add multiply, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (mul_go) begin
      mul_a_r <= mul_a_in;
      mul_p_r <= '0;
    end else if (mul_b_r != '0) begin
      if (mul_b_r[0]) mul_p_r <= mul_p_r + mul_a_r;
      mul_a_r <= mul_a_r << 1;
    end
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    logic [32:0] sh;
    logic        ge;
    sh = {div_rem_r[31:0], div_quo_r[DVD_W-1]};
    ge = (sh >= {1'b0, div_d_r});
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_go) begin
      div_cnt_r <= 7'(DVD_W);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 7'd1;
    end
    if (div_go) begin
      div_rem_r <= '0;
      div_quo_r <= div_n_in;
      div_d_r   <= div_d_in;
    end else if (div_cnt_r != '0) begin
      div_rem_r <= ge ? (sh - {1'b0, div_d_r}) : sh;
      div_quo_r <= {div_quo_r[DVD_W-2:0], ge};
    end
  end

  // digit-by-digit square root, two radicand bits a cycle
  always_ff @(posedge clk) begin
    logic [35:0] sh;
    logic [35:0] trial;
    logic        ge;
    sh    = {sq_rem_r[33:0], sq_v_r[63:62]};
    trial = {2'b0, sq_root_r, 2'b01};
    ge    = (sh >= trial);
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (sq_go) begin
      sq_cnt_r <= 6'd32;
    end else if (sq_cnt_r != '0) begin
      sq_cnt_r <= sq_cnt_r - 6'd1;
    end
    if (sq_go) begin
      sq_v_r    <= sq_in;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (sq_cnt_r != '0) begin
      sq_v_r    <= sq_v_r << 2;
      sq_rem_r  <= ge ? (sh - trial) : sh;
      sq_root_r <= {sq_root_r[30:0], ge};
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r     <= RST_BAND_COUNT;
      color_weight_r   <= RST_COLOR_W;
      compact_weight_r <= RST_COMPACT_W;
      scale_thr_r      <= RST_SCALE_THR;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        CFG_BAND_COUNT:      band_count_r     <= cfg_data[BCNT_W-1:0];
        CFG_COLOR_WEIGHT:    color_weight_r   <= cfg_data[WEIGHT_W-1:0];
        CFG_COMPACT_WEIGHT:  compact_weight_r <= cfg_data[WEIGHT_W-1:0];
        CFG_SCALE_THRESHOLD: scale_thr_r      <= cfg_data[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- region state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_a_r    <= '0;
      area_b_r    <= '0;
      perim_a_r   <= '0;
      perim_b_r   <= '0;
      box_ax_r    <= '0;
      box_ay_r    <= '0;
      box_aw_r    <= '0;
      box_ah_r    <= '0;
      box_bx_r    <= '0;
      box_by_r    <= '0;
      box_bw_r    <= '0;
      box_bh_r    <= '0;
      shared_r    <= '0;
      pa_mean_r   <= '0;
      pa_sq_r     <= '0;
      pa_sum_r    <= '0;
      pa_std_r    <= '0;
      color_acc_r <= '0;
      band_cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        case (in_mode)
          MODE_GEO_A: begin
            area_a_r    <= in_area;
            perim_a_r   <= in_perimeter;
            box_ax_r    <= in_box_x;
            box_ay_r    <= in_box_y;
            box_aw_r    <= in_box_w;
            box_ah_r    <= in_box_h;
            color_acc_r <= '0;
            band_cnt_r  <= '0;
          end
          MODE_GEO_B: begin
            area_b_r    <= in_area;
            perim_b_r   <= in_perimeter;
            box_bx_r    <= in_box_x;
            box_by_r    <= in_box_y;
            box_bw_r    <= in_box_w;
            box_bh_r    <= in_box_h;
            shared_r    <= in_shared_edges;
            color_acc_r <= '0;
            band_cnt_r  <= '0;
          end
          MODE_BAND_A: begin
            pa_mean_r <= in_band_mean;
            pa_sq_r   <= in_band_square_sum;
            pa_sum_r  <= in_band_color_sum;
            pa_std_r  <= in_band_std;
          end
          default: ;
        endcase
      end
      // fold this band's contribution into the colour sum
      if (commit && step_r == STP_MUL_ZB) begin
        color_acc_r <= sat48({{18{color_acc_r[47]}}, color_acc_r}
                             + $signed({2'b0, acc_r})
                             - $signed({2'b0, tmp_r})
                             - $signed({2'b0, mul_p_r}));
      end
      if (state_r == ST_ISSUE && step_r == STP_BAND_END && more_bands) begin
        band_cnt_r <= band_cnt_r + 4'd1;
      end
      if (state_r == ST_OUT && out_free) begin
        color_acc_r <= '0;
        band_cnt_r  <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- working registers
  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_BAND_B) begin
      pb_mean_r <= in_band_mean;
      pb_sq_r   <= in_band_square_sum;
      pb_sum_r  <= in_band_color_sum;
      pb_std_r  <= in_band_std;
    end
    if (mul_go) neg_r <= neg_in;
    if (commit) begin
      case (step_r)
        STP_MUL_MA:   acc_r  <= mul_p_r;
        STP_MUL_MB:   acc_r  <= acc_r + mul_p_r + 64'(area_sum >> 1);
        STP_DIV_MEAN: mean_r <= div_quo_r[MEAN_W:0];
        STP_MUL_MM: begin
          logic [64:0] s;
          s     = {1'b0, mul_p_r} + 65'd32768;
          tmp_r <= {16'b0, s[63:16]};
        end
        STP_MUL_T3:   acc_r <= mul_p_r;
        STP_MUL_T2:   tmp_r <= mul_p_r;
        STP_DIV_VAR:  tmp_r <= (div_quo_r > DVD_W'(MASK48)) ? MASK48 : div_quo_r[63:0];
        STP_SQRT_VAR: tmp_r <= 64'(sq_root_r);
        STP_MUL_Y:    acc_r <= mul_p_r;
        STP_MUL_ZA:   tmp_r <= mul_p_r;
        STP_MUL_ZB:   tmp_r <= tmp_r + mul_p_r;
        STP_MUL_COL: begin
          cost_r    <= rnd;
          smooth_r  <= '0;
          compact_r <= '0;
          k_r       <= 2'd0;
          shape_r   <= 1'b0;
        end
        STP_MUL_SMOOTH: tmp_r <= mul_p_r;
        STP_DIV_SMOOTH: begin
          if (k_r == 2'd0) smooth_r <= smooth_r + $signed(sterm);
          else             smooth_r <= smooth_r - $signed(sterm);
        end
        STP_SQRT_AREA: tmp_r <= 64'(sq_root_r);
        STP_MUL_COMPACT: begin
          logic signed [63:0] ct;
          ct = neg_r ? -$signed(mul_p_r) : $signed(mul_p_r);
          if (k_r == 2'd0) compact_r <= compact_r + ct;
          else             compact_r <= compact_r - ct;
          k_r <= k_r + 2'd1;
        end
        STP_W_COMPACT: acc_r <= rnd;
        STP_W_SMOOTH: begin
          logic signed [47:0] sp;
          sp    = sat48({{2{acc_r[63]}}, acc_r} + {{2{rnd[63]}}, rnd});
          acc_r <= 64'(sp);
        end
        STP_W_SPATIAL: begin
          logic signed [47:0] cs;
          cs      = sat48({{2{cost_r[63]}}, cost_r} + {{2{rnd[63]}}, rnd});
          cost_r  <= 64'(cs);
          shape_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_cost_r  <= cost_r[47:0];
      out_shape_r <= shape_r;
    end
  end

endmodule

@@ bench/region_merge_cost_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_merge_cost_tb: self-checking bench for the region merge cost block
// Streams region geometry and band statistics, predicts each fusion cost in
// fixed point alongside the block, and compares every result field by field
// over several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module region_merge_cost_tb;
  import rmc_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [20:0] area;
    logic [22:0] perim;
    logic [11:0] bx;
    logic [11:0] by;
    logic [12:0] bw;
    logic [12:0] bh;
    logic [21:0] shared;
    logic [23:0] mean;
    logic [35:0] sq;
    logic [27:0] sum;
    logic [23:0] std;
  } region_req_t;

  typedef struct {
    logic [47:0] cost;
    logic        shape;
  } cost_result_t;

  localparam longint S48_HI = (64'sd1 <<< 47) - 64'sd1;
  localparam longint S48_LO = -S48_HI - 64'sd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [20:0] in_area = '0;
  logic [22:0] in_perimeter = '0;
  logic [11:0] in_box_x = '0;
  logic [11:0] in_box_y = '0;
  logic [12:0] in_box_w = '0;
  logic [12:0] in_box_h = '0;
  logic [21:0] in_shared_edges = '0;
  logic [23:0] in_band_mean = '0;
  logic [35:0] in_band_square_sum = '0;
  logic [27:0] in_band_color_sum = '0;
  logic [23:0] in_band_std = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [47:0] out_merge_cost;
  logic              out_shape_included;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  region_merge_cost dut (.*);

  always #10 clk = ~clk;

  region_req_t  req_queue[$];
  cost_result_t cost_queue[$];
  region_req_t  cur_req;
  int           errors = 0;
  int           phase = 0;

  // predictor copy of registers and state
  longint unsigned p_bands, p_cw, p_kw, p_thr;
  longint unsigned p_area_a, p_area_b, p_perim_a, p_perim_b, p_shared;
  longint unsigned p_ax, p_ay, p_aw, p_ah, p_bx, p_by, p_bw, p_bh;
  longint unsigned p_mean, p_sq, p_sum, p_std;
  longint          p_acc;
  longint unsigned p_done;

  function automatic longint clip48(input longint v);
    if (v > S48_HI) return S48_HI;
    if (v < S48_LO) return S48_LO;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint weigh_q16(input longint a, input longint unsigned w);
    logic            neg;
    longint unsigned mag;
    longint unsigned r;
    neg = a < 0;
    mag = neg ? longint'(-a) : longint'(a);
    r = (mag * w + 64'd32768) >> 16;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned ratio_q16(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    if (den == 0) return 0;
    q = num / den;
    r = num % den;
    if (q >= (64'h1 << 40)) return 64'h1 << 56;
    return (q << 16) + ((r << 16) + den / 2) / den;
  endfunction

  function automatic longint smoothness(input longint unsigned area, input longint perim,
                                        input longint unsigned len);
    longint unsigned pm;
    longint          t;
    pm = (perim < 0) ? longint'(-perim) : longint'(perim);
    t = longint'(ratio_q16(area * pm, len));
    return (perim < 0) ? -t : t;
  endfunction

  function automatic longint compactness(input longint unsigned area, input longint perim);
    return perim * longint'(int_sqrt(area << 32));
  endfunction

  function automatic longint unsigned cap_weight(input longint unsigned w);
    return (w > 65536) ? 64'd65536 : w;
  endfunction

  function automatic longint band_heterogeneity(input region_req_t rb);
    longint unsigned a, b, tot, mean, t1, t2, t3, vs, var_q, sd;
    a = p_area_a;
    b = p_area_b;
    tot = a + b;
    if (tot == 0) return 0;
    mean = (p_mean * a + longint'(rb.mean) * b + tot / 2) / tot;
    t1 = (p_sq + longint'(rb.sq)) << 16;
    t2 = 64'd2 * mean * (p_sum + longint'(rb.sum));
    t3 = tot * ((mean * mean + 64'd32768) >> 16);
    vs = (t1 + t3 > t2) ? t1 + t3 - t2 : 0;
    var_q = vs / tot;
    if (var_q > MASK48) var_q = MASK48;
    sd = int_sqrt(var_q << 16);
    return longint'(tot * sd) - longint'(a * p_std + b * longint'(rb.std));
  endfunction

  function automatic longint shape_heterogeneity();
    longint unsigned am, la, lb, x0, y0, xa, xb, ya, yb, lm, kw;
    longint          pa, pb, pm, smooth, compact, spatial;
    am = p_area_a + p_area_b;
    pa = longint'(p_perim_a);
    pb = longint'(p_perim_b);
    pm = pa + pb - 2 * longint'(p_shared);
    la = 2 * (p_aw + p_ah);
    lb = 2 * (p_bw + p_bh);
    x0 = (p_ax < p_bx) ? p_ax : p_bx;
    y0 = (p_ay < p_by) ? p_ay : p_by;
    xa = p_ax + p_aw;
    xb = p_bx + p_bw;
    ya = p_ay + p_ah;
    yb = p_by + p_bh;
    lm = 2 * (((xa > xb) ? xa : xb) - x0 + ((ya > yb) ? ya : yb) - y0);
    smooth = clip48(smoothness(am, pm, lm) - smoothness(p_area_b, pb, lb)
                    - smoothness(p_area_a, pa, la));
    compact = clip48(compactness(am, pm) - compactness(p_area_b, pb)
                     - compactness(p_area_a, pa));
    kw = cap_weight(p_kw);
    spatial = weigh_q16(compact, kw) + weigh_q16(smooth, 64'd65536 - kw);
    return weigh_q16(clip48(spatial), 64'd65536 - cap_weight(p_cw));
  endfunction

  task automatic fold_request(input region_req_t r);
    longint unsigned nb;
    longint          cost;
    cost_result_t    res;
    if (r.mode == MODE_GEO_A || r.mode == MODE_GEO_B) begin
      if (r.mode == MODE_GEO_A) begin
        p_area_a = r.area; p_perim_a = r.perim;
        p_ax = r.bx; p_ay = r.by; p_aw = r.bw; p_ah = r.bh;
      end else begin
        p_area_b = r.area; p_perim_b = r.perim;
        p_bx = r.bx; p_by = r.by; p_bw = r.bw; p_bh = r.bh;
        p_shared = r.shared;
      end
      p_acc = 0;
      p_done = 0;
    end else if (r.mode == MODE_BAND_A) begin
      p_mean = r.mean; p_sq = r.sq; p_sum = r.sum; p_std = r.std;
    end else begin
      p_acc = clip48(p_acc + band_heterogeneity(r));
      nb = (p_bands == 0) ? 1 : ((p_bands > 8) ? 8 : p_bands);
      if (p_done + 1 < nb) begin
        p_done = (p_done + 1) & 64'hF;
      end else begin
        cost = weigh_q16(p_acc, cap_weight(p_cw));
        res.shape = 1'b0;
        if (cost < longint'(p_thr)) begin
          cost = clip48(cost + shape_heterogeneity());
          res.shape = 1'b1;
        end
        p_acc = 0;
        p_done = 0;
        res.cost = cost[47:0];
        cost_queue.insert(cost_queue.size(), res);
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) fold_request(cur_req);
      if (!in_valid || !in_stall) begin
        if (req_queue.size() != 0 &&
            !((phase == 1 && $urandom_range(0, 99) < 53) ||
              (phase == 3 && $urandom_range(0, 99) < 29))) begin
          cur_req = req_queue[0];
          req_queue.delete(0);
          in_valid <= 1'b1;
          in_mode <= cur_req.mode;
          in_area <= cur_req.area;
          in_perimeter <= cur_req.perim;
          in_box_x <= cur_req.bx;
          in_box_y <= cur_req.by;
          in_box_w <= cur_req.bw;
          in_box_h <= cur_req.bh;
          in_shared_edges <= cur_req.shared;
          in_band_mean <= cur_req.mean;
          in_band_square_sum <= cur_req.sq;
          in_band_color_sum <= cur_req.sum;
          in_band_std <= cur_req.std;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cost_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (cost_queue.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: cost %h shape %b", out_merge_cost,
                     out_shape_included);
        end else begin
          e = cost_queue[0];
          cost_queue.delete(0);
          if (out_merge_cost !== e.cost || out_shape_included !== e.shape) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected cost %h shape %b, got cost %h shape %b",
                       e.cost, e.shape, out_merge_cost, out_shape_included);
          end
        end
      end
      out_stall <= (phase == 2) ? ($urandom_range(0, 99) < 53) :
                   (phase == 3) ? ($urandom_range(0, 99) < 29) : 1'b0;
    end
  end

  task automatic add_req(input region_req_t r);
    req_queue.insert(req_queue.size(), r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BAND_COUNT:      p_bands = val & 48'hF;
      CFG_COLOR_WEIGHT:    p_cw = val & 48'h1FFFF;
      CFG_COMPACT_WEIGHT:  p_kw = val & 48'h1FFFF;
      CFG_SCALE_THRESHOLD: p_thr = val;
      default: ;
    endcase
  endtask

  function automatic region_req_t random_req(input logic [1:0] mode);
    region_req_t r;
    r.mode = mode;
    r.area = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(1, 64)) :
                                           21'($urandom_range(1, 1048576));
    r.perim = 23'($urandom_range(0, 4194304));
    r.bx = 12'($urandom_range(0, 4095));
    r.by = 12'($urandom_range(0, 4095));
    r.bw = 13'($urandom_range(1, 4096));
    r.bh = 13'($urandom_range(1, 4096));
    r.shared = 22'($urandom_range(0, 2097152));
    r.mean = 24'($urandom_range(0, 16777215));
    r.sq = {4'($urandom_range(0, 15)), 32'($urandom)};
    r.sum = 28'($urandom_range(0, 268435455));
    r.std = 24'($urandom_range(0, 16777215));
    return r;
  endfunction

  function automatic region_req_t edge_req(input logic [1:0] mode, input logic hi);
    region_req_t r;
    r.mode = mode;
    r.area = hi ? 21'd1048576 : 21'd1;
    r.perim = hi ? 23'd4194304 : 23'd0;
    r.bx = hi ? 12'd4095 : 12'd0;
    r.by = hi ? 12'd4095 : 12'd0;
    r.bw = hi ? 13'd4096 : 13'd1;
    r.bh = hi ? 13'd4096 : 13'd1;
    r.shared = hi ? 22'd2097152 : 22'd0;
    r.mean = hi ? 24'hFFFFFF : 24'd0;
    r.sq = hi ? 36'hF_FFFF_FFFF : 36'd0;
    r.sum = hi ? 28'hFFF_FFFF : 28'd0;
    r.std = hi ? 24'hFFFFFF : 24'd0;
    return r;
  endfunction

  task automatic wait_idle();
    while (req_queue.size() != 0 || in_valid || cost_queue.size() != 0) @(posedge clk);
    // trailing band requests with no result may still be in progress
    repeat (1500) @(posedge clk);
  endtask

  task automatic push_merge(input int nb);
    add_req(random_req(MODE_GEO_A));
    add_req(random_req(MODE_GEO_B));
    for (int i = 0; i < nb; i++) begin
      add_req(random_req(MODE_BAND_A));
      add_req(random_req(MODE_BAND_B));
    end
  endtask

  initial begin
    int pushed;
    int nb;
    int k;
    logic [47:0] thr;
    p_bands = RST_BAND_COUNT; p_cw = RST_COLOR_W; p_kw = RST_COMPACT_W; p_thr = RST_SCALE_THR;
    {p_area_a, p_area_b, p_perim_a, p_perim_b, p_shared} = '0;
    {p_ax, p_ay, p_aw, p_ah, p_bx, p_by, p_bw, p_bh} = '0;
    {p_mean, p_sq, p_sum, p_std, p_acc, p_done} = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // B band straight after reset: no A band, zero areas and zero boxes
    add_req(edge_req(MODE_BAND_B, 1'b1));
    add_req(edge_req(MODE_GEO_A, 1'b1));
    add_req(edge_req(MODE_GEO_B, 1'b0));
    add_req(edge_req(MODE_BAND_A, 1'b1));
    add_req(edge_req(MODE_BAND_B, 1'b0));
    add_req(edge_req(MODE_GEO_A, 1'b0));
    add_req(edge_req(MODE_GEO_B, 1'b1));
    add_req(edge_req(MODE_BAND_A, 1'b0));
    add_req(edge_req(MODE_BAND_B, 1'b1));
    add_req(edge_req(MODE_GEO_A, 1'b1));
    add_req(edge_req(MODE_GEO_B, 1'b1));
    add_req(edge_req(MODE_BAND_A, 1'b1));
    add_req(edge_req(MODE_BAND_B, 1'b1));
    // geometry in the middle clears the colour sum
    add_req(edge_req(MODE_BAND_A, 1'b1));
    add_req(edge_req(MODE_GEO_B, 1'b0));
    add_req(edge_req(MODE_BAND_B, 1'b1));
    add_req(random_req(MODE_BAND_B));
    wait_idle();

    pushed = 0;
    for (int chunk = 0; chunk < 12; chunk++) begin
      k = $urandom_range(0, 9);
      write_reg(CFG_BAND_COUNT, 48'((k == 0) ? 0 : (k == 1) ? 8 : (k == 2) ? 15 :
                                    (k == 3) ? 9 : $urandom_range(1, 3)));
      k = $urandom_range(0, 4);
      write_reg(CFG_COLOR_WEIGHT, 48'((k == 0) ? 0 : (k == 1) ? 65536 :
                                      (k == 2) ? 131071 : $urandom_range(0, 65536)));
      k = $urandom_range(0, 4);
      write_reg(CFG_COMPACT_WEIGHT, 48'((k == 0) ? 0 : (k == 1) ? 65536 :
                                        (k == 2) ? $urandom_range(65537, 131071) :
                                        $urandom_range(0, 65536)));
      k = $urandom_range(0, 4);
      thr = {16'($urandom), 32'($urandom)};
      write_reg(CFG_SCALE_THRESHOLD, (k == 0) ? 48'd0 : (k == 1) ? 48'hFFFF_FFFF_FFFF :
                                     (k == 2) ? 48'($urandom_range(0, 10000000)) : thr);
      phase = chunk % 4;
      for (int n = 0; n < 60; ) begin
        nb = (p_bands == 0) ? 1 : (p_bands > 8) ? 8 : int'(p_bands);
        k = $urandom_range(0, 99);
        if (k < 80) begin
          push_merge(nb);
          n += 2 + 2 * nb;
        end else if (k < 90) begin
          add_req(random_req(2'($urandom_range(0, 3))));
          n += 1;
        end else if (k < 95) begin
          // drop the A band: B reuses the held statistics
          add_req(random_req(MODE_GEO_A));
          add_req(random_req(MODE_GEO_B));
          add_req(random_req(MODE_BAND_B));
          n += 3;
        end else begin
          // truncated merge, restarted by the next geometry
          add_req(random_req(MODE_GEO_A));
          add_req(random_req(MODE_BAND_A));
          n += 2;
        end
      end
      wait_idle();
    end

    errors += cost_queue.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rmc_pkg.sv
hw/rtl/region_merge_cost.sv
bench/region_merge_cost_tb.sv
